/* rtl/core/dccpb_pkg.sv */
`default_nettype none

package dccpb_pkg;

    localparam int PKT_MAX_BYTES = 5;
    localparam int BODY_MAX_BYTES = 3;

    localparam logic [7:0] LONG_ADDR_PREFIX = 8'hC0;
    localparam logic [7:0] SPEED128_INSTR   = 8'h3F;
    localparam logic [7:0] POM_WRITE_BYTE   = 8'hEC;
    localparam logic [7:0] POM_WRITE_BIT    = 8'hE8;
    localparam logic [7:0] POM_READ_BYTE    = 8'hE4;
    localparam logic [7:0] POM_LONG_READ    = 8'hE0;
    localparam logic [7:0] ACC_INVERT       = 8'hF8;
    localparam logic [7:0] ACC_BASE         = 8'h80;
    localparam logic [7:0] BIT_OP_BASE      = 8'hF0;
    localparam logic [13:0] SHORT_ADDR_MAX  = 14'd127;
    localparam logic [1:0] CV_HIGH_MASK     = 2'b11;

    localparam logic [2:0] REP_THROTTLE = 3'd0;
    localparam logic [2:0] REP_FUNCTION = 3'd2;
    localparam logic [2:0] REP_DEFAULT  = 3'd3;
    localparam logic [2:0] REP_CV_BIT   = 3'd4;

    typedef enum logic [2:0] {
        CMD_THROTTLE      = 3'd0,
        CMD_FUNCTION      = 3'd1,
        CMD_ACCESSORY     = 3'd2,
        CMD_CV_WRITE_BYTE = 3'd3,
        CMD_CV_WRITE_BIT  = 3'd4,
        CMD_CV_READ_BYTE  = 3'd5,
        CMD_CV_LONG_READ  = 3'd6
    } cmd_t;

    typedef struct packed {
        cmd_t        command;
        logic [13:0] address;
        logic [7:0]  speed_code;
        logic [7:0]  function_first;
        logic [7:0]  function_second;
        logic [1:0]  accessory_output;
        logic        accessory_activate;
        logic [10:0] cv_number;
        logic [7:0]  cv_value;
        logic [2:0]  cv_bit_number;
        logic        cv_bit_value;
    } req_t;

    typedef struct packed {
        logic [PKT_MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                    count;
        logic [2:0]                    rep_count;
        cmd_t                          kind;
        logic [15:0]                   railcom_address;
    } pkt_t;

endpackage

`default_nettype wire

/* rtl/core/dccpb_encoder.sv */
`default_nettype none

module dccpb_encoder (
    input  var dccpb_pkg::req_t req,
    output var dccpb_pkg::pkt_t pkt
);

    logic                                  long_addr;
    logic [7:0]                            addr_lo;
    logic [7:0]                            addr_hi;
    logic [9:0]                            cv_dec;
    logic [7:0]                            acc0;
    logic [7:0]                            acc1;
    logic [1:0][7:0]                       pre;
    logic [1:0]                            pre_n;
    logic [dccpb_pkg::BODY_MAX_BYTES-1:0][7:0] body;
    logic [1:0]                            body_n;
    logic [2:0]                            off;

    always_comb begin
        long_addr = req.address > dccpb_pkg::SHORT_ADDR_MAX;
        addr_lo   = req.address[7:0];
        addr_hi   = dccpb_pkg::LONG_ADDR_PREFIX | {2'b00, req.address[13:8]};
        // one-based CV number, wraps at 1024
        cv_dec    = req.cv_number[9:0] - 10'd1;
        acc0      = dccpb_pkg::ACC_BASE | {2'b00, req.address[5:0]};
        acc1      = {1'b0, req.address[8:6], 1'b0, req.accessory_output,
                     req.accessory_activate} ^ dccpb_pkg::ACC_INVERT;

        pre[0] = long_addr ? addr_hi : addr_lo;
        pre[1] = addr_lo;
        pre_n  = long_addr ? 2'd2 : 2'd1;
        body   = '0;
        body_n = 2'd0;
        pkt.rep_count = dccpb_pkg::REP_DEFAULT;

        case (req.command)
            dccpb_pkg::CMD_THROTTLE: begin
                body[0] = dccpb_pkg::SPEED128_INSTR;
                body[1] = req.speed_code;
                body_n  = 2'd2;
                pkt.rep_count = dccpb_pkg::REP_THROTTLE;
            end
            dccpb_pkg::CMD_FUNCTION: begin
                if (req.function_first != 8'd0) begin
                    body[0] = req.function_first;
                    body[1] = req.function_second;
                    body_n  = 2'd2;
                end else begin
                    body[0] = req.function_second;
                    body_n  = 2'd1;
                end
                pkt.rep_count = dccpb_pkg::REP_FUNCTION;
            end
            dccpb_pkg::CMD_ACCESSORY: begin
                pre_n   = 2'd0;
                body[0] = acc0;
                body[1] = acc1;
                body_n  = 2'd2;
            end
            dccpb_pkg::CMD_CV_WRITE_BYTE: begin
                body[0] = dccpb_pkg::POM_WRITE_BYTE
                          | {6'd0, cv_dec[9:8] & dccpb_pkg::CV_HIGH_MASK};
                body[1] = cv_dec[7:0];
                body[2] = req.cv_value;
                body_n  = 2'd3;
            end
            dccpb_pkg::CMD_CV_WRITE_BIT: begin
                body[0] = dccpb_pkg::POM_WRITE_BIT
                          | {6'd0, cv_dec[9:8] & dccpb_pkg::CV_HIGH_MASK};
                body[1] = cv_dec[7:0];
                body[2] = dccpb_pkg::BIT_OP_BASE
                          | {4'd0, req.cv_bit_value, req.cv_bit_number};
                body_n  = 2'd3;
                pkt.rep_count = dccpb_pkg::REP_CV_BIT;
            end
            dccpb_pkg::CMD_CV_READ_BYTE: begin
                body[0] = dccpb_pkg::POM_READ_BYTE
                          | {6'd0, cv_dec[9:8] & dccpb_pkg::CV_HIGH_MASK};
                body[1] = cv_dec[7:0];
                body[2] = 8'd0;
                body_n  = 2'd3;
            end
            dccpb_pkg::CMD_CV_LONG_READ: begin
                body[0] = dccpb_pkg::POM_LONG_READ
                          | {6'd0, cv_dec[9:8] & dccpb_pkg::CV_HIGH_MASK};
                body[1] = cv_dec[7:0];
                body_n  = 2'd2;
            end
            default: begin
                // unused command code: empty packet, dropped downstream
                pre_n  = 2'd0;
                body_n = 2'd0;
            end
        endcase

        off = 3'd0;
        for (int i = 0; i < dccpb_pkg::PKT_MAX_BYTES; i++) begin
            off = 3'(i) - {1'b0, pre_n};
            if (3'(i) < {1'b0, pre_n}) begin
                pkt.bytes[3'(i)] = pre[1'(i)];
            end else if (off < 3'(dccpb_pkg::BODY_MAX_BYTES)) begin
                pkt.bytes[3'(i)] = body[off[1:0]];
            end else begin
                pkt.bytes[3'(i)] = 8'd0;
            end
        end

        pkt.count = {1'b0, pre_n} + {1'b0, body_n};
        pkt.kind  = req.command;
        if (req.command == dccpb_pkg::CMD_ACCESSORY) begin
            pkt.railcom_address = {acc0, acc1};
        end else if (long_addr) begin
            pkt.railcom_address = {addr_hi, addr_lo};
        end else begin
            pkt.railcom_address = {8'd0, addr_lo};
        end
    end

endmodule

`default_nettype wire

/* rtl/core/dccpb_serializer.sv */
`default_nettype none

module dccpb_serializer (
    input  var logic            aclk,
    input  var logic            aresetn,
    input  var logic            in_valid,
    input  var dccpb_pkg::pkt_t in_pkt,
    output var logic            in_ready,
    output var logic            m_tvalid,
    input  var logic            m_tready,
    output var logic [31:0]     m_tdata,  // packet_byte[7:0], repeat_count[10:8],
                                          // railcom_address[26:11], zero pad
    output var logic            m_tlast,
    output var logic [2:0]      m_tuser   // packet_kind[2:0]
);

    dccpb_pkg::pkt_t pkt_reg, pkt_next;
    logic            pkt_valid_reg, pkt_valid_next;
    logic [2:0]      idx_reg, idx_next;
    logic            last;
    logic            fire;

    assign last     = idx_reg == (pkt_reg.count - 3'd1);
    assign fire     = pkt_valid_reg && m_tready;
    assign in_ready = !pkt_valid_reg || (fire && last);

    always_comb begin
        pkt_next       = pkt_reg;
        pkt_valid_next = pkt_valid_reg;
        idx_next       = idx_reg;
        if (fire && !last) begin
            idx_next = idx_reg + 3'd1;
        end
        if (in_ready) begin
            // empty packets are swallowed here
            pkt_valid_next = in_valid && (in_pkt.count != 3'd0);
            pkt_next       = in_pkt;
            idx_next       = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end else begin
            pkt_valid_reg <= pkt_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        pkt_reg <= pkt_next;
    end

    assign m_tvalid = pkt_valid_reg;
    assign m_tlast  = last;
    assign m_tuser  = pkt_reg.kind;
    assign m_tdata  = {5'd0, pkt_reg.railcom_address, pkt_reg.rep_count,
                       pkt_reg.bytes[idx_reg]};

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pkt_valid_reg |-> (idx_reg < pkt_reg.count))
        else $error("byte index beyond packet length");

    a_no_empty_pkt: assert property (@(posedge aclk) disable iff (!aresetn)
        pkt_valid_reg |-> (pkt_reg.count != 3'd0
                           && pkt_reg.count <= 3'(dccpb_pkg::PKT_MAX_BYTES)))
        else $error("held packet has bad length");

    a_idx_step: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !last |=> pkt_valid_reg && idx_reg == $past(idx_reg) + 3'd1)
        else $error("byte index did not advance after beat");

    a_new_pkt_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready && in_valid && in_pkt.count != 3'd0 |=> idx_reg == 3'd0)
        else $error("new packet does not start at first byte");

endmodule

`default_nettype wire

/* rtl/core/dcc_packet_payload_builder_unit.sv */
// Path: an accepted beat is registered in the input stage, encoded combinationally,
// then registered in the byte serializer. Output: a packet of n bytes (n = 2..5) goes
// out one byte per beat while m_tready is high; the byte serializer sets the rate, and
// the input register holds the next request. An unused command code gives no beat.
// Reset: synchronous, active low; clears the input and packet valid flags.
`default_nettype none

module dcc_packet_payload_builder_unit (
    input  var logic        aclk,
    input  var logic        aresetn,
    input  var logic        s_tvalid,
    output var logic        s_tready,
    input  var logic [63:0] s_tdata,  // address[13:0], speed_code[21:14],
                                      // function_first[29:22], function_second[37:30],
                                      // accessory_output[39:38], accessory_activate[40],
                                      // cv_number[51:41], cv_value[59:52],
                                      // cv_bit_number[62:60], cv_bit_value[63]
    input  var logic [2:0]  s_tuser,  // command[2:0]
    output var logic        m_tvalid,
    input  var logic        m_tready,
    output var logic [31:0] m_tdata,  // packet_byte[7:0], repeat_count[10:8],
                                      // railcom_address[26:11], zero pad
    output var logic        m_tlast,
    output var logic [2:0]  m_tuser   // packet_kind[2:0]
);

    dccpb_pkg::req_t req_reg, req_next;
    logic            in_valid_reg, in_valid_next;
    dccpb_pkg::pkt_t enc_pkt;
    logic            enc_ready;
    logic            s_fire;

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = !in_valid_reg || enc_ready;

    always_comb begin
        req_next                    = req_reg;
        in_valid_next               = in_valid_reg;
        if (enc_ready) begin
            in_valid_next = 1'b0;
        end
        if (s_fire) begin
            in_valid_next                = 1'b1;
            req_next.command             = dccpb_pkg::cmd_t'(s_tuser);
            req_next.address             = s_tdata[13:0];
            req_next.speed_code          = s_tdata[21:14];
            req_next.function_first      = s_tdata[29:22];
            req_next.function_second     = s_tdata[37:30];
            req_next.accessory_output    = s_tdata[39:38];
            req_next.accessory_activate  = s_tdata[40];
            req_next.cv_number           = s_tdata[51:41];
            req_next.cv_value            = s_tdata[59:52];
            req_next.cv_bit_number       = s_tdata[62:60];
            req_next.cv_bit_value        = s_tdata[63];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
    end

    dccpb_encoder u_encoder (
        .req (req_reg),
        .pkt (enc_pkt)
    );

    dccpb_serializer u_serializer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid_reg),
        .in_pkt   (enc_pkt),
        .in_ready (enc_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam logic [3:0] PREDICTED  = 4'hF;

    // one command request; the typed_* fields hold a hand-worked packet,
    // typed_bytes first byte in the highest used byte
    typedef struct packed {
        logic [2:0]  code;
        logic [13:0] addr;
        logic [7:0]  spd;
        logic [7:0]  f1;
        logic [7:0]  f2;
        logic [1:0]  acc_out;
        logic        acc_act;
        logic [10:0] cv_num;
        logic [7:0]  cv_val;
        logic [2:0]  bit_num;
        logic        bit_val;
        logic [3:0]  n_typed;
        logic [39:0] typed_bytes;
        logic [2:0]  typed_rep;
        logic [15:0] typed_rc;
    } cmd_row_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [2:0]  rep;
        logic [2:0]  kind;
        logic [15:0] rc;
    } beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;

    beat_t payload_due[$];
    beat_t due;
    int    bad_beats = 0;
    int    calm_tx = 0;
    int    calm_rx = 0;
    int    stall_left = 0;

    dcc_packet_payload_builder_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic cmd_row_t row(logic [2:0] code, logic [13:0] addr, logic [7:0] spd,
                                     logic [7:0] f1, logic [7:0] f2, logic [1:0] aout,
                                     logic aact, logic [10:0] cvn, logic [7:0] cvv,
                                     logic [2:0] bn, logic bv, logic [3:0] n_typed,
                                     logic [39:0] typed, logic [2:0] trep, logic [15:0] trc);
        cmd_row_t r;
        r.code = code;         r.addr = addr;       r.spd = spd;
        r.f1 = f1;             r.f2 = f2;           r.acc_out = aout;
        r.acc_act = aact;      r.cv_num = cvn;      r.cv_val = cvv;
        r.bit_num = bn;        r.bit_val = bv;      r.n_typed = n_typed;
        r.typed_bytes = typed; r.typed_rep = trep;  r.typed_rc = trc;
        return r;
    endfunction

    // bytes packed first-byte-highest: byte k sits at 8*(n-1-k)
    function automatic void queue_packet(logic [39:0] pay, int n, logic [2:0] rep,
                                         logic [2:0] kind, logic [15:0] rc);
        beat_t b;
        for (int k = 0; k < n; k++) begin
            b.data = pay[8*(n-1-k) +: 8];
            b.last = (k == n - 1);
            b.rep  = rep;
            b.kind = kind;
            b.rc   = rc;
            payload_due.push_back(b);
        end
    endfunction

    function automatic void encode_packet(cmd_row_t r);
        logic [39:0] pay;
        int          n;
        logic [2:0]  rep;
        logic [15:0] rc;
        logic [9:0]  cv_idx;
        logic [7:0]  hi;
        logic [7:0]  acc_lo;
        pay = '0;
        n = 0;
        rep = '0;
        rc = '0;
        // one based, so bit 10 of the CV number drops out of the wrap
        cv_idx = r.cv_num[9:0] - 10'd1;
        if (r.code != dccpb_pkg::CMD_ACCESSORY && r.code != CMD_UNUSED) begin
            if (r.addr > dccpb_pkg::SHORT_ADDR_MAX) begin
                hi = {2'b00, r.addr[13:8]} | dccpb_pkg::LONG_ADDR_PREFIX;
                pay = {pay[31:0], hi};
                rc[15:8] = hi;
                n++;
            end
            pay = {pay[31:0], r.addr[7:0]};
            rc[7:0] = r.addr[7:0];
            n++;
        end
        case (r.code)
            dccpb_pkg::CMD_THROTTLE: begin
                pay = {pay[23:0], dccpb_pkg::SPEED128_INSTR, r.spd};
                n += 2;
                rep = dccpb_pkg::REP_THROTTLE;
            end
            dccpb_pkg::CMD_FUNCTION: begin
                if (r.f1 != 8'h00) begin
                    pay = {pay[31:0], r.f1};
                    n++;
                end
                pay = {pay[31:0], r.f2};
                n++;
                rep = dccpb_pkg::REP_FUNCTION;
            end
            dccpb_pkg::CMD_ACCESSORY: begin
                hi = dccpb_pkg::ACC_BASE + {2'b00, r.addr[5:0]};
                acc_lo = ({1'b0, r.addr[8:6], 4'b0000} + {5'b0, r.acc_out, 1'b0}
                          + {7'b0, r.acc_act}) ^ dccpb_pkg::ACC_INVERT;
                pay = {32'b0, hi, acc_lo};
                rc = {hi, acc_lo};
                n = 2;
                rep = dccpb_pkg::REP_DEFAULT;
            end
            dccpb_pkg::CMD_CV_WRITE_BYTE: begin
                pay = {pay[15:0], dccpb_pkg::POM_WRITE_BYTE + {6'b0, cv_idx[9:8]},
                       cv_idx[7:0], r.cv_val};
                n += 3;
                rep = dccpb_pkg::REP_DEFAULT;
            end
            dccpb_pkg::CMD_CV_WRITE_BIT: begin
                pay = {pay[15:0], dccpb_pkg::POM_WRITE_BIT + {6'b0, cv_idx[9:8]},
                       cv_idx[7:0],
                       dccpb_pkg::BIT_OP_BASE + {4'b0, r.bit_val, r.bit_num}};
                n += 3;
                rep = dccpb_pkg::REP_CV_BIT;
            end
            dccpb_pkg::CMD_CV_READ_BYTE: begin
                pay = {pay[15:0], dccpb_pkg::POM_READ_BYTE + {6'b0, cv_idx[9:8]},
                       cv_idx[7:0], 8'h00};
                n += 3;
                rep = dccpb_pkg::REP_DEFAULT;
            end
            dccpb_pkg::CMD_CV_LONG_READ: begin
                pay = {pay[23:0], dccpb_pkg::POM_LONG_READ + {6'b0, cv_idx[9:8]},
                       cv_idx[7:0]};
                n += 2;
                rep = dccpb_pkg::REP_DEFAULT;
            end
            default: begin
                n = 0;
            end
        endcase
        queue_packet(pay, n, rep, r.code, rc);
    endfunction

    // mostly short gaps, a few long ones, and now and then a calm stretch
    function automatic int pick_gap(inout int calm_left);
        int roll;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
            calm_left = $urandom_range(20, 60);
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic cmd_row_t random_row();
        cmd_row_t r;
        logic [63:0] noise;
        int sel;
        noise = {$urandom, $urandom};
        {r.bit_val, r.bit_num, r.cv_val, r.cv_num, r.acc_act, r.acc_out,
         r.f2, r.f1, r.spd, r.addr} = noise;
        r.code = ($urandom_range(0, 99) < 5) ? CMD_UNUSED : 3'($urandom_range(0, 6));
        sel = $urandom_range(0, 9);
        case (sel)
            0: r.addr = 14'd0;
            1: r.addr = $urandom_range(0, 1) ? 14'd127 : 14'd128;
            2: r.addr = 14'h3FFF;
            3, 4, 5: r.addr = 14'($urandom_range(0, 127));
            default: ;
        endcase
        sel = $urandom_range(0, 9);
        case (sel)
            0: r.cv_num = 11'd0;
            1: r.cv_num = 11'd1;
            2: r.cv_num = 11'd1024;
            3: r.cv_num = 11'h7FF;
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0)
            r.f1 = 8'h00;
        r.n_typed = PREDICTED;
        r.typed_bytes = '0;
        r.typed_rep = '0;
        r.typed_rc = '0;
        return r;
    endfunction

    task automatic send_row(cmd_row_t r);
        int gap;
        gap = pick_gap(calm_tx);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        if (r.n_typed == PREDICTED)
            encode_packet(r);
        else
            queue_packet(r.typed_bytes, int'(r.n_typed), r.typed_rep, r.code, r.typed_rc);
        s_tdata  = {r.bit_val, r.bit_num, r.cv_val, r.cv_num, r.acc_act, r.acc_out,
                    r.f2, r.f1, r.spd, r.addr};
        s_tuser  = r.code;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    initial begin
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap(calm_rx);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (payload_due.size() == 0) begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display("unexpected beat: byte %h last %b user %0d",
                             m_tdata[7:0], m_tlast, m_tuser);
            end else begin
                due = payload_due.pop_front();
                if (m_tdata[7:0] !== due.data || m_tlast !== due.last
                    || m_tdata[10:8] !== due.rep || m_tuser !== due.kind
                    || m_tdata[26:11] !== due.rc) begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display({"beat mismatch: byte %h/%h last %b/%b rep %0d/%0d ",
                                  "kind %0d/%0d railcom %h/%h (expected/actual)"},
                                 due.data, m_tdata[7:0], due.last, m_tlast,
                                 due.rep, m_tdata[10:8], due.kind, m_tuser,
                                 due.rc, m_tdata[26:11]);
                end
            end
        end
    end

    initial begin
        cmd_row_t dir_tab[$];
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // unused command code, all fields low and all high
        dir_tab.push_back(row(CMD_UNUSED, 14'd0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0, 11'd0,
                              8'h00, 3'd0, 1'b0, 4'd0, 40'h0, 3'd0, 16'h0000));
        dir_tab.push_back(row(CMD_UNUSED, 14'h3FFF, 8'hFF, 8'hFF, 8'hFF, 2'd3, 1'b1, 11'h7FF,
                              8'hFF, 3'd7, 1'b1, 4'd0, 40'h0, 3'd0, 16'h0000));
        // broadcast address, short address limit, long address edges
        dir_tab.push_back(row(dccpb_pkg::CMD_THROTTLE, 14'd0, 8'h00, 8'h00, 8'h00, 2'd0,
                              1'b0, 11'd0, 8'h00, 3'd0, 1'b0, 4'd3, 40'h00_3F_00,
                              dccpb_pkg::REP_THROTTLE, 16'h0000));
        dir_tab.push_back(row(dccpb_pkg::CMD_THROTTLE, 14'd127, 8'hFF, 8'h00, 8'h00, 2'd0,
                              1'b0, 11'd0, 8'h00, 3'd0, 1'b0, 4'd3, 40'h7F_3F_FF,
                              dccpb_pkg::REP_THROTTLE, 16'h007F));
        dir_tab.push_back(row(dccpb_pkg::CMD_THROTTLE, 14'd128, 8'h80, 8'h00, 8'h00, 2'd0,
                              1'b0, 11'd0, 8'h00, 3'd0, 1'b0, PREDICTED, 40'h0, 3'd0,
                              16'h0000));
        dir_tab.push_back(row(dccpb_pkg::CMD_THROTTLE, 14'h3FFF, 8'h7F, 8'hFF, 8'hFF, 2'd3,
                              1'b1, 11'h7FF, 8'hFF, 3'd7, 1'b1, PREDICTED, 40'h0, 3'd0,
                              16'h0000));
        // function byte omitted, present, and all ones
        dir_tab.push_back(row(dccpb_pkg::CMD_FUNCTION, 14'd3, 8'h00, 8'h00, 8'h80, 2'd0,
                              1'b0, 11'd0, 8'h00, 3'd0, 1'b0, PREDICTED, 40'h0, 3'd0,
                              16'h0000));
        dir_tab.push_back(row(dccpb_pkg::CMD_FUNCTION, 14'h3FFF, 8'h00, 8'hFF, 8'hFF, 2'd0,
                              1'b0, 11'd0, 8'h00, 3'd0, 1'b0, PREDICTED, 40'h0, 3'd0,
                              16'h0000));
        dir_tab.push_back(row(dccpb_pkg::CMD_FUNCTION, 14'd200, 8'h00, 8'hDE, 8'h00, 2'd0,
                              1'b0, 11'd0, 8'h00, 3'd0, 1'b0, PREDICTED, 40'h0, 3'd0,
                              16'h0000));
        // accessory: only address bits 8..0 count
        dir_tab.push_back(row(dccpb_pkg::CMD_ACCESSORY, 14'd0, 8'h00, 8'h00, 8'h00, 2'd0,
                              1'b0, 11'd0, 8'h00, 3'd0, 1'b0, 4'd2, 40'h80_F8,
                              dccpb_pkg::REP_DEFAULT, 16'h80F8));
        dir_tab.push_back(row(dccpb_pkg::CMD_ACCESSORY, 14'h3FFF, 8'h00, 8'h00, 8'h00, 2'd3,
                              1'b1, 11'd0, 8'h00, 3'd0, 1'b0, PREDICTED, 40'h0, 3'd0,
                              16'h0000));
        dir_tab.push_back(row(dccpb_pkg::CMD_ACCESSORY, 14'd511, 8'h00, 8'h00, 8'h00, 2'd2,
                              1'b0, 11'd0, 8'h00, 3'd0, 1'b0, PREDICTED, 40'h0, 3'd0,
                              16'h0000));
        dir_tab.push_back(row(dccpb_pkg::CMD_ACCESSORY, 14'd512, 8'h00, 8'h00, 8'h00, 2'd1,
                              1'b1, 11'd0, 8'h00, 3'd0, 1'b0, PREDICTED, 40'h0, 3'd0,
                              16'h0000));
        // CV numbers: first, zero wrapping to the top, 1024, beyond 1024
        dir_tab.push_back(row(dccpb_pkg::CMD_CV_WRITE_BYTE, 14'd0, 8'h00, 8'h00, 8'h00,
                              2'd0, 1'b0, 11'd1, 8'h00, 3'd0, 1'b0, 4'd4, 40'h00_EC_00_00,
                              dccpb_pkg::REP_DEFAULT, 16'h0000));
        dir_tab.push_back(row(dccpb_pkg::CMD_CV_WRITE_BYTE, 14'h3FFF, 8'h00, 8'h00, 8'h00,
                              2'd0, 1'b0, 11'd1024, 8'hFF, 3'd0, 1'b0, PREDICTED, 40'h0,
                              3'd0, 16'h0000));
        dir_tab.push_back(row(dccpb_pkg::CMD_CV_WRITE_BYTE, 14'd5, 8'h00, 8'h00, 8'h00,
                              2'd0, 1'b0, 11'd0, 8'h5A, 3'd0, 1'b0, PREDICTED, 40'h0,
                              3'd0, 16'h0000));
        dir_tab.push_back(row(dccpb_pkg::CMD_CV_WRITE_BYTE, 14'd300, 8'h00, 8'h00, 8'h00,
                              2'd0, 1'b0, 11'h7FF, 8'hA5, 3'd0, 1'b0, PREDICTED, 40'h0,
                              3'd0, 16'h0000));
        dir_tab.push_back(row(dccpb_pkg::CMD_CV_WRITE_BIT, 14'd3, 8'h00, 8'h00, 8'h00,
                              2'd0, 1'b0, 11'd1, 8'h00, 3'd0, 1'b0, 4'd4, 40'h03_E8_00_F0,
                              dccpb_pkg::REP_CV_BIT, 16'h0003));
        dir_tab.push_back(row(dccpb_pkg::CMD_CV_WRITE_BIT, 14'h3FFF, 8'h00, 8'h00, 8'h00,
                              2'd0, 1'b0, 11'd1025, 8'h00, 3'd7, 1'b1, PREDICTED, 40'h0,
                              3'd0, 16'h0000));
        dir_tab.push_back(row(dccpb_pkg::CMD_CV_READ_BYTE, 14'd127, 8'h00, 8'h00, 8'h00,
                              2'd0, 1'b0, 11'd256, 8'hFF, 3'd0, 1'b0, PREDICTED, 40'h0,
                              3'd0, 16'h0000));
        dir_tab.push_back(row(dccpb_pkg::CMD_CV_READ_BYTE, 14'd128, 8'h00, 8'h00, 8'h00,
                              2'd0, 1'b0, 11'd0, 8'h00, 3'd0, 1'b0, PREDICTED, 40'h0,
                              3'd0, 16'h0000));
        dir_tab.push_back(row(dccpb_pkg::CMD_CV_LONG_READ, 14'd0, 8'h00, 8'h00, 8'h00,
                              2'd0, 1'b0, 11'd1, 8'h00, 3'd0, 1'b0, 4'd3, 40'h00_E0_00,
                              dccpb_pkg::REP_DEFAULT, 16'h0000));
        dir_tab.push_back(row(dccpb_pkg::CMD_CV_LONG_READ, 14'd9999, 8'h00, 8'h00, 8'h00,
                              2'd0, 1'b0, 11'h7FF, 8'h00, 3'd0, 1'b0, PREDICTED, 40'h0,
                              3'd0, 16'h0000));

        foreach (dir_tab[i])
            send_row(dir_tab[i]);
        repeat (207)
            send_row(random_row());
        s_tvalid = 1'b0;

        while (payload_due.size() != 0)
            @(posedge aclk);
        // let any stray beat surface
        repeat (20) @(posedge aclk);
        if (bad_beats == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* dcc_packet_payload_builder_unit.f */
rtl/core/dccpb_pkg.sv
rtl/core/dccpb_encoder.sv
rtl/core/dccpb_serializer.sv
rtl/core/dcc_packet_payload_builder_unit.sv
tb/sv/tb.sv
